### hw/rtl/rsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_pkg
// Types, widths, constants and pipeline stage map of the ray/segment
// intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // coordinate and angle widths
  localparam int CW  = 32;            // Q16.16 coordinate width
  localparam int AGW = 19;            // Q3.16 angle width
  localparam int CS  = 16;            // CORDIC steps, at most 24
  localparam int ZW  = 27;            // CORDIC datapath width, Q.24

  // derived datapath widths
  localparam int SW    = 18;                // sine / cosine, Q.16
  localparam int ATW   = CW + 1;            // segment direction terms
  localparam int CTW   = 2 * CW + 1;        // segment line constant
  localparam int COW   = CW + SW + 1;       // ray line constant
  localparam int CO_LO = COW / 2;           // split point of the ray constant
  localparam int DW    = ATW + SW + 2;      // determinant
  localparam int NW    = CTW + SW + 2;      // numerators
  localparam int MW    = NW + 1;            // divider compare width

  localparam logic signed [AGW:0]  HALF_PI_Q = 20'sd102944;
  localparam logic signed [AGW:0]  PI_Q      = 20'sd205887;
  localparam logic signed [ZW-1:0] CORDIC_GAIN_Q24 = 27'sd10188012;

  localparam logic signed [ZW-1:0] ATAN_Q24 [0:23] = '{
    27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331,
    27'sd1047214,  27'sd524117,  27'sd262123,  27'sd131069,
    27'sd65536,    27'sd32768,   27'sd16384,   27'sd8192,
    27'sd4096,     27'sd2048,    27'sd1024,    27'sd512,
    27'sd256,      27'sd128,     27'sd64,      27'sd32,
    27'sd16,       27'sd8,       27'sd4,       27'sd2
  };

  // stage map
  localparam int ST_SC   = CS + 2;       // sine / cosine
  localparam int ST_P1   = CS + 3;       // first partial products
  localparam int ST_P2   = CS + 4;       // det, ray constant, ct products summed
  localparam int ST_P3   = CS + 5;       // ray constant partial products
  localparam int ST_P4   = CS + 6;       // ray constant products summed
  localparam int ST_N    = CS + 7;       // numerators
  localparam int ST_MAG  = CS + 8;       // magnitudes and signs
  localparam int ST_OVF  = CS + 9;       // range precheck, divider entry
  localparam int ST_QUO  = ST_OVF + CW + 1;
  localparam int NST     = ST_QUO + 1;

  typedef struct packed {
    logic signed [AGW-1:0] ray_angle;
    logic signed [CW-1:0]  ray_x;
    logic signed [CW-1:0]  ray_y;
    logic signed [CW-1:0]  seg_ax;
    logic signed [CW-1:0]  seg_ay;
    logic signed [CW-1:0]  seg_bx;
    logic signed [CW-1:0]  seg_by;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
  } out_t;

  typedef struct packed {
    logic signed [ATW-1:0] at;
    logic signed [ATW-1:0] bt;
    logic signed [CTW-1:0] ct;
  } seg_t;

endpackage
`default_nettype wire

### hw/rtl/ray_segment_intersection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_segment_intersection
// Streaming 2D ray / line segment intersection in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction carries a ray (angle in Q3.16 radians, origin)
//           and one segment (two endpoints). in_valid / in_ready handshake.
//   out_* : one transaction per input: hit flag and intersection point.
//   Throughput is one transaction per cycle while the output is not stalled:
//   every stage is a register slice and a new item may enter each cycle in
//   which the pipeline advances. On the way to out_valid, the accepting edge
//   loads the input stage; the item then passes 1 angle fold stage, 16 CORDIC
//   step stages, 1 sine/cosine stage, 6 multiply/add/magnitude stages, 1 range
//   precheck, 32 restoring divider stages (one quotient bit each), 1 quotient
//   stage and the output register. The divider dominates.
//   A zero determinant or a quotient outside the 32-bit range reports a
//   miss with a zero point.
//   Reset (rst_n low, synchronous) clears all stage valid bits and the
//   output valid; payload registers are not reset.
//   When the receiver stalls with a result pending, the pipeline holds only
//   if its last stage carries an item; otherwise it keeps advancing, so
//   bubbles collapse and new inputs are still taken.
// ----------------------------------------------------------------------------
module ray_segment_intersection (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rsi_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rsi_pkg::out_t      out_data
);

  localparam int CW    = rsi_pkg::CW;
  localparam int AGW   = rsi_pkg::AGW;
  localparam int CS    = rsi_pkg::CS;
  localparam int ZW    = rsi_pkg::ZW;
  localparam int SW    = rsi_pkg::SW;
  localparam int ATW   = rsi_pkg::ATW;
  localparam int COW   = rsi_pkg::COW;
  localparam int CO_LO = rsi_pkg::CO_LO;
  localparam int DW    = rsi_pkg::DW;
  localparam int NW    = rsi_pkg::NW;
  localparam int MW    = rsi_pkg::MW;
  localparam int NST   = rsi_pkg::NST;

  // --------------------------------------------------------------------------
  // Flow control: one enable for all stages
  // --------------------------------------------------------------------------
  logic [NST-1:0]    v_r;
  logic              en;
  logic              out_valid_r;
  rsi_pkg::out_t     out_data_r;

  // hold only when the tail item has nowhere to go
  assign en       = !(out_valid_r && !out_ready && v_r[NST-1]);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // raw inputs travel with every item to the last stage
  rsi_pkg::in_t base_r [0:rsi_pkg::ST_QUO];

  always_ff @(posedge clk) begin
    if (en) begin
      base_r[0] <= in_data;
      for (int k = 1; k <= rsi_pkg::ST_QUO; k++) begin
        base_r[k] <= base_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: fold angle into [-pi/2, pi/2], segment terms and ct products
  // --------------------------------------------------------------------------
  logic signed [AGW:0]    ang_e;
  logic signed [AGW:0]    ang_red;
  logic                   flip;
  logic signed [ATW-1:0]  at_r, bt_r;
  logic signed [2*CW-1:0] p_byax_r, p_aybx_r;

  always_comb begin
    ang_e = (AGW+1)'(base_r[0].ray_angle);
    if (ang_e > rsi_pkg::HALF_PI_Q) begin
      ang_red = ang_e - rsi_pkg::PI_Q;
      flip    = 1'b1;
    end else if (ang_e < -rsi_pkg::HALF_PI_Q) begin
      ang_red = ang_e + rsi_pkg::PI_Q;
      flip    = 1'b1;
    end else begin
      ang_red = ang_e;
      flip    = 1'b0;
    end
  end

  // CORDIC state, index j holds the value after j steps
  logic signed [ZW-1:0] cx_r [0:CS];
  logic signed [ZW-1:0] cy_r [0:CS];
  logic signed [ZW-1:0] cz_r [0:CS];
  logic                 cf_r [0:CS];

  always_ff @(posedge clk) begin
    if (en) begin
      at_r     <= ATW'(base_r[0].seg_ay) - ATW'(base_r[0].seg_by);
      bt_r     <= ATW'(base_r[0].seg_bx) - ATW'(base_r[0].seg_ax);
      p_byax_r <= base_r[0].seg_by * base_r[0].seg_ax;
      p_aybx_r <= base_r[0].seg_ay * base_r[0].seg_bx;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC: load the folded angle, then one rotation step per stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= rsi_pkg::CORDIC_GAIN_Q24;
      cy_r[0] <= '0;
      cz_r[0] <= ZW'(ang_red) <<< 8;
      cf_r[0] <= flip;
      for (int j = 0; j < CS; j++) begin
        cf_r[j+1] <= cf_r[j];
        if (cz_r[j] >= 0) begin
          cx_r[j+1] <= cx_r[j] - (cy_r[j] >>> j);
          cy_r[j+1] <= cy_r[j] + (cx_r[j] >>> j);
          cz_r[j+1] <= cz_r[j] - rsi_pkg::ATAN_Q24[j];
        end else begin
          cx_r[j+1] <= cx_r[j] + (cy_r[j] >>> j);
          cy_r[j+1] <= cy_r[j] - (cx_r[j] >>> j);
          cz_r[j+1] <= cz_r[j] + rsi_pkg::ATAN_Q24[j];
        end
      end
    end
  end

  // segment terms ride alongside the CORDIC stages
  rsi_pkg::seg_t sg_r [2:rsi_pkg::ST_P2];

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r[2].at <= at_r;
      sg_r[2].bt <= bt_r;
      sg_r[2].ct <= rsi_pkg::CTW'(p_byax_r) - rsi_pkg::CTW'(p_aybx_r);
      for (int k = 3; k <= rsi_pkg::ST_P2; k++) begin
        sg_r[k] <= sg_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sine / cosine: undo the fold, floor Q.24 down to Q.16
  // --------------------------------------------------------------------------
  logic signed [ZW-1:0] xs, ys;
  logic signed [SW-1:0] s_r;
  logic signed [SW:0]   bo_r;

  always_comb begin
    xs = cf_r[CS] ? -cx_r[CS] : cx_r[CS];
    ys = cf_r[CS] ? -cy_r[CS] : cy_r[CS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= SW'(ys >>> 8);
      bo_r <= -((SW+1)'(xs >>> 8));
    end
  end

  // --------------------------------------------------------------------------
  // P1: partial products of the ray line, det and the ct terms
  // --------------------------------------------------------------------------
  rsi_pkg::seg_t          sg_sc;
  logic signed [SW:0]     c_sc;
  logic signed [CW+SW:0]  p_yc_r, p_xs_r;
  logic signed [SW+ATW-1:0] p_aobt_r;
  logic signed [SW+ATW:0]   p_atbo_r;
  logic signed [SW+CW+1:0]  p_boctl_r;
  logic signed [SW+ATW:0]   p_bocth_r;
  logic signed [SW+CW:0]    p_aoctl_r;
  logic signed [SW+ATW-1:0] p_aocth_r;

  assign sg_sc = sg_r[rsi_pkg::ST_SC];
  assign c_sc  = -bo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_yc_r    <= base_r[rsi_pkg::ST_SC].ray_y * c_sc;
      p_xs_r    <= base_r[rsi_pkg::ST_SC].ray_x * s_r;
      p_aobt_r  <= s_r * sg_sc.bt;
      p_atbo_r  <= sg_sc.at * bo_r;
      p_boctl_r <= bo_r * $signed({1'b0, sg_sc.ct[CW-1:0]});
      p_bocth_r <= bo_r * $signed(sg_sc.ct[rsi_pkg::CTW-1:CW]);
      p_aoctl_r <= s_r * $signed({1'b0, sg_sc.ct[CW-1:0]});
      p_aocth_r <= s_r * $signed(sg_sc.ct[rsi_pkg::CTW-1:CW]);
    end
  end

  // --------------------------------------------------------------------------
  // P2: det, ray constant co, bo*ct and ao*ct
  // --------------------------------------------------------------------------
  logic signed [COW-1:0] co_r;
  logic signed [DW-1:0]  det_p2_r;
  logic signed [NW-1:0]  boct_p2_r, aoct_p2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      co_r      <= COW'(p_yc_r) - COW'(p_xs_r);
      det_p2_r  <= DW'(p_aobt_r) - DW'(p_atbo_r);
      boct_p2_r <= (NW'(p_bocth_r) <<< CW) + NW'(p_boctl_r);
      aoct_p2_r <= (NW'(p_aocth_r) <<< CW) + NW'(p_aoctl_r);
    end
  end

  // --------------------------------------------------------------------------
  // P3: bt*co and at*co as two partial products each
  // --------------------------------------------------------------------------
  rsi_pkg::seg_t                sg_p2;
  logic signed [ATW+CO_LO:0]    p_btcol_r, p_atcol_r;
  logic signed [ATW+COW-CO_LO-1:0] p_btcoh_r, p_atcoh_r;
  logic signed [DW-1:0]         det_p3_r;
  logic signed [NW-1:0]         boct_p3_r, aoct_p3_r;

  assign sg_p2 = sg_r[rsi_pkg::ST_P2];

  always_ff @(posedge clk) begin
    if (en) begin
      p_btcol_r <= sg_p2.bt * $signed({1'b0, co_r[CO_LO-1:0]});
      p_btcoh_r <= sg_p2.bt * $signed(co_r[COW-1:CO_LO]);
      p_atcol_r <= sg_p2.at * $signed({1'b0, co_r[CO_LO-1:0]});
      p_atcoh_r <= sg_p2.at * $signed(co_r[COW-1:CO_LO]);
      det_p3_r  <= det_p2_r;
      boct_p3_r <= boct_p2_r;
      aoct_p3_r <= aoct_p2_r;
    end
  end

  // --------------------------------------------------------------------------
  // P4: combine partial products
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] btco_r, atco_r, boct_p4_r, aoct_p4_r;
  logic signed [DW-1:0] det_p4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      btco_r    <= (NW'(p_btcoh_r) <<< CO_LO) + NW'(p_btcol_r);
      atco_r    <= (NW'(p_atcoh_r) <<< CO_LO) + NW'(p_atcol_r);
      boct_p4_r <= boct_p3_r;
      aoct_p4_r <= aoct_p3_r;
      det_p4_r  <= det_p3_r;
    end
  end

  // --------------------------------------------------------------------------
  // N: Cramer numerators
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [DW-1:0] det_n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r    <= boct_p4_r - btco_r;
      ny_r    <= atco_r - aoct_p4_r;
      det_n_r <= det_p4_r;
    end
  end

  // --------------------------------------------------------------------------
  // MAG: magnitudes and quotient signs
  // --------------------------------------------------------------------------
  logic [NW-1:0] mx_r, my_r;
  logic [DW-1:0] md_r;
  logic          negx_m_r, negy_m_r, dz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r     <= nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
      my_r     <= ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
      md_r     <= det_n_r[DW-1] ? DW'(-det_n_r) : DW'(det_n_r);
      negx_m_r <= nx_r[NW-1] ^ det_n_r[DW-1];
      negy_m_r <= ny_r[NW-1] ^ det_n_r[DW-1];
      dz_r     <= (det_n_r == '0);
    end
  end

  // --------------------------------------------------------------------------
  // OVF + divider: flag quotients of 2^CW or more, then one bit per stage
  // --------------------------------------------------------------------------
  logic [NW-1:0] rx_r [0:CW];
  logic [NW-1:0] ry_r [0:CW];
  logic [CW-1:0] qx_r [0:CW];
  logic [CW-1:0] qy_r [0:CW];
  logic [DW-1:0] dd_r [0:CW];
  logic          ngx_r [0:CW];
  logic          ngy_r [0:CW];
  logic          bad_r [0:CW];
  logic [MW-1:0] dsh_ovf;

  assign dsh_ovf = MW'(md_r) << CW;

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]  <= mx_r;
      ry_r[0]  <= my_r;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      dd_r[0]  <= md_r;
      ngx_r[0] <= negx_m_r;
      ngy_r[0] <= negy_m_r;
      bad_r[0] <= dz_r || (MW'(mx_r) >= dsh_ovf) || (MW'(my_r) >= dsh_ovf);
      for (int j = 0; j < CW; j++) begin
        dd_r[j+1]  <= dd_r[j];
        ngx_r[j+1] <= ngx_r[j];
        ngy_r[j+1] <= ngy_r[j];
        bad_r[j+1] <= bad_r[j];
        if (MW'(rx_r[j]) >= (MW'(dd_r[j]) << (CW-1-j))) begin
          rx_r[j+1] <= rx_r[j] - NW'(MW'(dd_r[j]) << (CW-1-j));
          qx_r[j+1] <= qx_r[j] | (CW'(1) << (CW-1-j));
        end else begin
          rx_r[j+1] <= rx_r[j];
          qx_r[j+1] <= qx_r[j];
        end
        if (MW'(ry_r[j]) >= (MW'(dd_r[j]) << (CW-1-j))) begin
          ry_r[j+1] <= ry_r[j] - NW'(MW'(dd_r[j]) << (CW-1-j));
          qy_r[j+1] <= qy_r[j] | (CW'(1) << (CW-1-j));
        end else begin
          ry_r[j+1] <= ry_r[j];
          qy_r[j+1] <= qy_r[j];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // QUO: signed range check, apply sign, zero a rejected point
  // --------------------------------------------------------------------------
  logic [CW-1:0]        limx, limy;
  logic                 qbad;
  logic                 ok_r;
  logic signed [CW-1:0] px_r, py_r;

  always_comb begin
    limx = {1'b1, {(CW-1){1'b0}}} - CW'(!ngx_r[CW]);
    limy = {1'b1, {(CW-1){1'b0}}} - CW'(!ngy_r[CW]);
    qbad = bad_r[CW] || (qx_r[CW] > limx) || (qy_r[CW] > limy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= !qbad;
      if (qbad) begin
        px_r <= '0;
        py_r <= '0;
      end else begin
        px_r <= ngx_r[CW] ? -$signed(qx_r[CW]) : $signed(qx_r[CW]);
        py_r <= ngy_r[CW] ? -$signed(qy_r[CW]) : $signed(qy_r[CW]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output: bounding box and in-front test, then the output register
  // --------------------------------------------------------------------------
  rsi_pkg::in_t         bq;
  logic signed [CW-1:0] maxx, minx, maxy, miny;
  logic                 inbox, ahead, hit_c;

  assign bq = base_r[rsi_pkg::ST_QUO];

  always_comb begin
    maxy  = (bq.seg_ay > bq.seg_by) ? bq.seg_ay : bq.seg_by;
    miny  = (bq.seg_ay < bq.seg_by) ? bq.seg_ay : bq.seg_by;
    maxx  = (bq.seg_ax > bq.seg_bx) ? bq.seg_ax : bq.seg_bx;
    minx  = (bq.seg_ax < bq.seg_bx) ? bq.seg_ax : bq.seg_bx;
    inbox = !(py_r > maxy || py_r < miny || px_r < minx || px_r > maxx);
    if (bq.ray_angle < 0) begin
      ahead = (bq.ray_angle > -rsi_pkg::HALF_PI_Q && bq.ray_x < px_r && bq.ray_y > py_r) ||
              (bq.ray_angle < -rsi_pkg::HALF_PI_Q && bq.ray_x > px_r && bq.ray_y > py_r);
    end else begin
      ahead = (bq.ray_angle < rsi_pkg::HALF_PI_Q && bq.ray_x < px_r && bq.ray_y < py_r) ||
              (bq.ray_angle > rsi_pkg::HALF_PI_Q && bq.ray_x > px_r && bq.ray_y < py_r);
    end
    hit_c = ok_r && inbox && ahead;
  end

  // load a new result whenever the output register is free or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= v_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r.hit   <= hit_c;
      out_data_r.hit_x <= px_r;
      out_data_r.hit_y <= py_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
